### sv/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

    localparam int unsigned POS_W     = 12;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 1'b1;

    localparam logic [POS_W-1:0] MAX_X_RESET = 12'd1024;
    localparam logic [POS_W-1:0] MAX_Y_RESET = 12'd768;

    // Status and header bit positions.
    localparam int unsigned STATUS_READY_BIT = 0;
    localparam int unsigned STATUS_AUX_BIT   = 5;
    localparam int unsigned HDR_X_SIGN_BIT   = 4;
    localparam int unsigned HDR_Y_SIGN_BIT   = 5;
    localparam int unsigned HDR_X_OVF_BIT    = 6;
    localparam int unsigned HDR_Y_OVF_BIT    = 7;

    // Position of the next byte within a packet.
    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_X_MOVE = 2'd1;
    localparam logic [1:0] IDX_Y_MOVE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] status_byte;
        logic [BYTE_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0] pointer_x;
        logic [POS_W-1:0] pointer_y;
    } out_word_t;

endpackage

### sv/ps2_mouse_packet_tracker_unit.sv
// Top level of the PS/2 mouse packet tracker: input register, tracker, result register.
//
// Usage:
//   Input channel (in_valid, in_stall, in_word) carries one controller status
//   byte with its data byte per word. Words whose status lacks data ready or
//   auxiliary source are dropped. Every third accepted mouse byte completes a
//   packet; packets without overflow move the pointer and give one output word.
//   Output channel (out_valid, out_stall, out_word) carries the clamped
//   pointer_x and pointer_y.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) writes max_x
//   (index 0) and max_y (index 1); cfg_ready is always high.
// Timing:
//   One word per cycle is accepted while in_stall is low. An accepted word
//   waits in the input register, where the position add and clamp run, and its
//   result then waits in the result register until it is taken.
// Reset:
//   Clears both pipeline registers, the packet index and the pointer position;
//   max_x returns to 1024 and max_y to 768.
// Stall:
//   While a result waits under out_stall, words that produce no result still
//   pass; a word that would produce one waits in the input register and
//   in_stall rises.
module ps2_mouse_packet_tracker_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ps2mpt_pkg::in_word_t              in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ps2mpt_pkg::out_word_t             out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mpt_pkg::POS_W-1:0]      cfg_data
);

    logic                          in_valid_reg;
    ps2mpt_pkg::in_word_t          in_word_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ps2mpt_pkg::out_word_t         out_word_reg;
    logic [ps2mpt_pkg::POS_W-1:0]  max_x_reg;
    logic [ps2mpt_pkg::POS_W-1:0]  max_y_reg;

    logic                          produce;
    ps2mpt_pkg::out_word_t         result;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    // The result slot is free when empty or being taken this cycle.
    assign out_free = ~out_valid_reg | ~out_stall;
    // The registered word moves on unless it needs the result slot and that is busy.
    assign advance  = in_valid_reg & (~produce | out_free);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    ps2mpt_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_word_reg),
        .advance    (advance),
        .max_x      (max_x_reg),
        .max_y      (max_y_reg),
        .produce    (produce),
        .result     (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (advance && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_word_reg <= result;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= ps2mpt_pkg::MAX_X_RESET;
            max_y_reg <= ps2mpt_pkg::MAX_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ps2mpt_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                ps2mpt_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                default:               max_x_reg <= max_x_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A waiting result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(advance && produce))
        else $error("result register overwritten while stalled");

    // A word that needs the busy result slot holds the input side.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && produce && out_valid_reg && out_stall) |=> in_valid_reg)
        else $error("pending word lost while output stalled");

    // A word leaving the input register without a new one empties it.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_take) |=> !in_valid_reg)
        else $error("input register not emptied after advance");
`endif

endmodule

### sv/ps2mpt_tracker.sv
// Packet assembly and pointer position update for one registered byte.
module ps2mpt_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  ps2mpt_pkg::in_word_t          item,
    input  logic                          advance,
    input  logic [ps2mpt_pkg::POS_W-1:0]  max_x,
    input  logic [ps2mpt_pkg::POS_W-1:0]  max_y,
    output logic                          produce,
    output ps2mpt_pkg::out_word_t         result
);

    logic [1:0]                        byte_idx_reg;
    logic [1:0]                        byte_idx_next;
    logic [ps2mpt_pkg::BYTE_W-1:0]     header_reg;
    logic [ps2mpt_pkg::BYTE_W-1:0]     header_next;
    logic [ps2mpt_pkg::BYTE_W-1:0]     x_move_reg;
    logic [ps2mpt_pkg::BYTE_W-1:0]     x_move_next;
    logic [ps2mpt_pkg::POS_W-1:0]      pos_x_reg;
    logic [ps2mpt_pkg::POS_W-1:0]      pos_x_next;
    logic [ps2mpt_pkg::POS_W-1:0]      pos_y_reg;
    logic [ps2mpt_pkg::POS_W-1:0]      pos_y_next;

    logic                              byte_ok;
    logic                              last_byte;
    logic                              overflow;
    logic signed [ps2mpt_pkg::POS_W+1:0] move_x;
    logic signed [ps2mpt_pkg::POS_W+1:0] move_y;
    logic signed [ps2mpt_pkg::POS_W+1:0] sum_x;
    logic signed [ps2mpt_pkg::POS_W+1:0] sum_y;
    logic [ps2mpt_pkg::POS_W-1:0]      clamp_x;
    logic [ps2mpt_pkg::POS_W-1:0]      clamp_y;

    // A byte counts only when the controller marks it ready and from the mouse.
    assign byte_ok = item_valid
                   & item.status_byte[ps2mpt_pkg::STATUS_READY_BIT]
                   & item.status_byte[ps2mpt_pkg::STATUS_AUX_BIT];
    // An index of 3 cannot arise; it is treated like the last byte.
    assign last_byte = byte_idx_reg[1];
    assign overflow  = header_reg[ps2mpt_pkg::HDR_X_OVF_BIT]
                     | header_reg[ps2mpt_pkg::HDR_Y_OVF_BIT];
    assign produce   = byte_ok & last_byte & ~overflow;

    // Nine-bit movement values sign-extended from the header sign bits.
    assign move_x = {{6{header_reg[ps2mpt_pkg::HDR_X_SIGN_BIT]}}, x_move_reg};
    assign move_y = {{6{header_reg[ps2mpt_pkg::HDR_Y_SIGN_BIT]}}, item.data_byte};
    assign sum_x  = $signed({2'b00, pos_x_reg}) + move_x;
    assign sum_y  = $signed({2'b00, pos_y_reg}) - move_y;

    // Clamp each coordinate to zero and the configured maximum.
    always_comb
    begin
        if (sum_x < 0)
        begin
            clamp_x = '0;
        end
        else if (sum_x > $signed({2'b00, max_x}))
        begin
            clamp_x = max_x;
        end
        else
        begin
            clamp_x = sum_x[ps2mpt_pkg::POS_W-1:0];
        end

        if (sum_y < 0)
        begin
            clamp_y = '0;
        end
        else if (sum_y > $signed({2'b00, max_y}))
        begin
            clamp_y = max_y;
        end
        else
        begin
            clamp_y = sum_y[ps2mpt_pkg::POS_W-1:0];
        end
    end

    assign result.pointer_x = clamp_x;
    assign result.pointer_y = clamp_y;

    // Next-state logic for packet gathering and the kept position.
    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        header_next   = header_reg;
        x_move_next   = x_move_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        if (advance && byte_ok)
        begin
            case (byte_idx_reg)
                ps2mpt_pkg::IDX_HEADER:
                begin
                    header_next   = item.data_byte;
                    byte_idx_next = ps2mpt_pkg::IDX_X_MOVE;
                end
                ps2mpt_pkg::IDX_X_MOVE:
                begin
                    x_move_next   = item.data_byte;
                    byte_idx_next = ps2mpt_pkg::IDX_Y_MOVE;
                end
                default:
                begin
                    byte_idx_next = ps2mpt_pkg::IDX_HEADER;
                    if (!overflow)
                    begin
                        pos_x_next = clamp_x;
                        pos_y_next = clamp_y;
                    end
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= ps2mpt_pkg::IDX_HEADER;
            header_reg   <= '0;
            x_move_reg   <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            header_reg   <= header_next;
            x_move_reg   <= x_move_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The packet index never reaches the unused code.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg != 2'd3)
        else $error("packet byte index reached 3");

    // A position is only emitted on the last byte of a packet.
    a_produce_last: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (byte_idx_reg == ps2mpt_pkg::IDX_Y_MOVE))
        else $error("result produced outside the last packet byte");

    // An updated position never exceeds the maximum in force at the update.
    a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce) |=> (pos_x_reg <= $past(max_x)) && (pos_y_reg <= $past(max_y)))
        else $error("position update exceeds configured maximum");

    // A rejected byte leaves the packet state alone.
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !byte_ok) |=> $stable(byte_idx_reg) && $stable(pos_x_reg)
                                  && $stable(pos_y_reg))
        else $error("rejected byte changed tracker state");
`endif

endmodule
